// File: src/assert_macros.svh
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GDBO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define GDBO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// File: src/gdbo_pkg.sv
// Package: sizes, opcodes, emit control word and bit helpers of the traversal core
`timescale 1ns / 1ps

package gdbo_pkg;

  localparam int MaxVertices = 64;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int VtxW        = $clog2(MaxVertices + 1);

  // input opcodes
  localparam logic OpEdge = 1'b0;
  localparam logic OpRun  = 1'b1;

  // sequencer to output stage
  typedef struct packed {
    logic            push;    // new vertex in visit order
    logic            finish;  // run done, release held vertex as last
    logic [VtxW-1:0] vertex;
  } emit_req_t;

  // one-hot bit for a zero-based vertex index
  function automatic logic [MaxVertices-1:0] idx_onehot(input logic [IdxW-1:0] idx);
    logic [MaxVertices-1:0] v;
    v = '0;
    v[idx] = 1'b1;
    return v;
  endfunction

  // index of the lowest set bit, zero if none
  function automatic logic [IdxW-1:0] lowest_index(input logic [MaxVertices-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (v[i]) r = IdxW'(i);
    end
    return r;
  endfunction

endpackage

// File: src/gdbo_intf.sv
// Interfaces: command word channel and visit word channel
`timescale 1ns / 1ps

interface gdbo_in_if;
  import gdbo_pkg::*;
  logic            valid;
  logic            ready;
  logic            opcode;
  logic [VtxW-1:0] vertex_a;
  logic [VtxW-1:0] vertex_b;
  logic            breadth_first;

  modport source (output valid, opcode, vertex_a, vertex_b, breadth_first, input ready);
  modport sink   (input valid, opcode, vertex_a, vertex_b, breadth_first, output ready);
endinterface

interface gdbo_out_if;
  import gdbo_pkg::*;
  logic            valid;
  logic            ready;
  logic [VtxW-1:0] visited_vertex;
  logic            last_of_run;

  modport source (output valid, visited_vertex, last_of_run, input ready);
  modport sink   (input valid, visited_vertex, last_of_run, output ready);
endinterface

// File: src/gdbo_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
`timescale 1ns / 1ps

module gdbo_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/gdbo_out_stage.sv
// Output stage: holds back one vertex so the last one of a run can be flagged
`timescale 1ns / 1ps

module gdbo_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gdbo_pkg::emit_req_t         emit_i,
  output logic                        can_emit_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gdbo_pkg::VtxW-1:0]   out_vertex_o,
  output logic                        out_last_o
);
  import gdbo_pkg::*;

  logic            out_valid_q, out_valid_d;
  logic [VtxW-1:0] out_vertex_q;
  logic            out_last_q;
  logic            hold_v_q, hold_v_d;
  logic [VtxW-1:0] hold_q;
  logic            can;
  logic            load;

  // output register is free or being drained this cycle
  assign can  = !out_valid_q || out_ready_i;
  assign load = can && hold_v_q && (emit_i.push || emit_i.finish);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    hold_v_d = hold_v_q;
    if (can && emit_i.push) begin
      hold_v_d = 1'b1;
    end else if (can && emit_i.finish) begin
      hold_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hold_v_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      hold_v_q    <= hold_v_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_vertex_q <= hold_q;
      out_last_q   <= emit_i.finish;
    end
    if (can && emit_i.push) hold_q <= emit_i.vertex;
  end

  assign can_emit_o   = can;
  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_last_o   = out_last_q;

endmodule

// File: src/graph_dfs_bfs_order_core.sv
// Top level: adjacency-matrix graph with depth-first and breadth-first traversal
`timescale 1ns / 1ps

// Keeps an undirected graph of up to 64 vertices (numbered from one) as a 64x64
// adjacency bit matrix in a synchronous RAM; per-row valid flops make the matrix read
// as empty right after reset, so no clearing pass is needed. An add-edge word does a
// read-modify-write of both rows. A run word walks from vertex_a and sends
// one word per visited vertex, last_of_run set on the final one. One item is worked
// on at a time; each visited vertex waits on a read of its adjacency row, and each
// pop or dequeue on a read of the stack/queue RAM. Lowest unvisited neighbour is
// found by a priority encoder over the row, limited to 1..vertex_count.
// Output back-pressure stalls the walk.
module graph_dfs_bfs_order_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gdbo_in_if.sink                   in_i,
  gdbo_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [gdbo_pkg::VtxW-1:0] cfg_wdata_i
);
  import gdbo_pkg::*;

  // sequencer states
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StEdgeRa = 4'd1;
  localparam logic [3:0] StEdgeWa = 4'd2;
  localparam logic [3:0] StEdgeRb = 4'd3;
  localparam logic [3:0] StEdgeWb = 4'd4;
  localparam logic [3:0] StDStart = 4'd5;
  localparam logic [3:0] StDScan  = 4'd6;
  localparam logic [3:0] StDPop   = 4'd7;
  localparam logic [3:0] StBDeq   = 4'd8;
  localparam logic [3:0] StBEmit  = 4'd9;
  localparam logic [3:0] StBScan  = 4'd10;
  localparam logic [3:0] StFlush  = 4'd11;

  logic [3:0]             state_q, state_d;
  logic [VtxW-1:0]        vcount_q;
  logic [MaxVertices-1:0] vis_q, vis_d;
  logic [MaxVertices-1:0] row_vld_q;
  logic                   rowvld_rd_q;
  logic [IdxW-1:0]        cur_q, cur_d;
  logic [IdxW-1:0]        ea_q, ea_d, eb_q, eb_d;
  logic [VtxW-1:0]        depth_q, depth_d;
  logic [VtxW-1:0]        head_q, head_d, tail_q, tail_d;

  logic                   adj_we, adj_re;
  logic [IdxW-1:0]        adj_waddr, adj_raddr;
  logic [MaxVertices-1:0] adj_wdata, adj_rdata;
  logic                   wk_we, wk_re;
  logic [IdxW-1:0]        wk_waddr, wk_raddr;
  logic [IdxW-1:0]        wk_wdata, wk_rdata;

  logic                   in_fire;
  logic                   a_ok, b_ok;
  logic [IdxW-1:0]        a_idx, b_idx;
  logic [VtxW-1:0]        n_eff;
  logic [MaxVertices-1:0] nmask;
  logic [MaxVertices-1:0] row_eff;
  logic [MaxVertices-1:0] cand;
  logic                   cand_any;
  logic [IdxW-1:0]        nx;
  logic [VtxW-1:0]        depth_m1;
  emit_req_t              emit;
  logic                   can_emit;

  // memories
  gdbo_ram #(.Width(MaxVertices), .Depth(MaxVertices)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  gdbo_ram #(.Width(IdxW), .Depth(MaxVertices)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (wk_we),
    .waddr_i (wk_waddr),
    .wdata_i (wk_wdata),
    .re_i    (wk_re),
    .raddr_i (wk_raddr),
    .rdata_o (wk_rdata)
  );

  gdbo_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .can_emit_o   (can_emit),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_vertex_o (out_o.visited_vertex),
    .out_last_o   (out_o.last_of_run)
  );

  // input decode
  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign a_ok       = (in_i.vertex_a != '0) && (in_i.vertex_a <= VtxW'(MaxVertices));
  assign b_ok       = (in_i.vertex_b != '0) && (in_i.vertex_b <= VtxW'(MaxVertices));
  assign a_idx      = IdxW'(in_i.vertex_a - VtxW'(1));
  assign b_idx      = IdxW'(in_i.vertex_b - VtxW'(1));

  // neighbour range 1..min(vertex_count, max)
  assign n_eff = (vcount_q > VtxW'(MaxVertices)) ? VtxW'(MaxVertices) : vcount_q;
  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      nmask[i] = (VtxW'(i) < n_eff);
    end
  end

  // rows never written read as empty
  assign row_eff  = rowvld_rd_q ? adj_rdata : '0;
  assign cand     = row_eff & ~vis_q & nmask;
  assign cand_any = |cand;
  assign nx       = lowest_index(cand);
  assign depth_m1 = depth_q - VtxW'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    vis_d   = vis_q;
    cur_d   = cur_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    depth_d = depth_q;
    head_d  = head_q;
    tail_d  = tail_q;

    adj_we    = 1'b0;
    adj_waddr = ea_q;
    adj_wdata = row_eff | idx_onehot(eb_q);
    adj_re    = 1'b0;
    adj_raddr = cur_q;

    wk_we    = 1'b0;
    wk_waddr = depth_q[IdxW-1:0];
    wk_wdata = cur_q;
    wk_re    = 1'b0;
    wk_raddr = head_q[IdxW-1:0];

    emit = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_i.opcode == OpEdge) begin
            if (a_ok && b_ok) begin
              ea_d    = a_idx;
              eb_d    = b_idx;
              state_d = StEdgeRa;
            end
          end else if (a_ok) begin
            vis_d = idx_onehot(a_idx);
            if (in_i.breadth_first) begin
              wk_we    = 1'b1;
              wk_waddr = '0;
              wk_wdata = a_idx;
              head_d   = '0;
              tail_d   = VtxW'(1);
              state_d  = StBDeq;
            end else begin
              cur_d   = a_idx;
              depth_d = '0;
              state_d = StDStart;
            end
          end
        end
      end
      // edge: read-modify-write row a, then row b
      StEdgeRa: begin
        adj_re    = 1'b1;
        adj_raddr = ea_q;
        state_d   = StEdgeWa;
      end
      StEdgeWa: begin
        adj_we    = 1'b1;
        adj_waddr = ea_q;
        adj_wdata = row_eff | idx_onehot(eb_q);
        state_d   = StEdgeRb;
      end
      StEdgeRb: begin
        adj_re    = 1'b1;
        adj_raddr = eb_q;
        state_d   = StEdgeWb;
      end
      StEdgeWb: begin
        adj_we    = 1'b1;
        adj_waddr = eb_q;
        adj_wdata = row_eff | idx_onehot(ea_q);
        state_d   = StIdle;
      end
      // depth first: top of stack lives in cur_q, the rest in the work RAM
      StDStart: begin
        if (can_emit) begin
          emit.push   = 1'b1;
          emit.vertex = VtxW'(cur_q) + VtxW'(1);
          adj_re      = 1'b1;
          adj_raddr   = cur_q;
          state_d     = StDScan;
        end
      end
      StDScan: begin
        if (cand_any) begin
          if (can_emit) begin
            emit.push   = 1'b1;
            emit.vertex = VtxW'(nx) + VtxW'(1);
            vis_d       = vis_q | idx_onehot(nx);
            wk_we       = 1'b1;
            wk_waddr    = depth_q[IdxW-1:0];
            wk_wdata    = cur_q;
            depth_d     = depth_q + VtxW'(1);
            cur_d       = nx;
            adj_re      = 1'b1;
            adj_raddr   = nx;
          end
        end else if (depth_q == '0) begin
          state_d = StFlush;
        end else begin
          wk_re    = 1'b1;
          wk_raddr = depth_m1[IdxW-1:0];
          depth_d  = depth_m1;
          state_d  = StDPop;
        end
      end
      StDPop: begin
        cur_d     = wk_rdata;
        adj_re    = 1'b1;
        adj_raddr = wk_rdata;
        state_d   = StDScan;
      end
      // breadth first: queue in the work RAM between head and tail
      StBDeq: begin
        if (head_q < tail_q) begin
          wk_re    = 1'b1;
          wk_raddr = head_q[IdxW-1:0];
          head_d   = head_q + VtxW'(1);
          state_d  = StBEmit;
        end else begin
          state_d = StFlush;
        end
      end
      StBEmit: begin
        if (can_emit) begin
          emit.push   = 1'b1;
          emit.vertex = VtxW'(wk_rdata) + VtxW'(1);
          adj_re      = 1'b1;
          adj_raddr   = wk_rdata;
          state_d     = StBScan;
        end
      end
      StBScan: begin
        if (cand_any) begin
          vis_d    = vis_q | idx_onehot(nx);
          wk_we    = 1'b1;
          wk_waddr = tail_q[IdxW-1:0];
          wk_wdata = nx;
          tail_d   = tail_q + VtxW'(1);
        end else begin
          state_d = StBDeq;
        end
      end
      StFlush: begin
        if (can_emit) begin
          emit.finish = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vcount_q    <= VtxW'(MaxVertices);
      vis_q       <= '0;
      row_vld_q   <= '0;
      rowvld_rd_q <= 1'b0;
      cur_q       <= '0;
      ea_q        <= '0;
      eb_q        <= '0;
      depth_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
    end else begin
      state_q <= state_d;
      vis_q   <= vis_d;
      cur_q   <= cur_d;
      ea_q    <= ea_d;
      eb_q    <= eb_d;
      depth_q <= depth_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (adj_we) row_vld_q[adj_waddr] <= 1'b1;
      if (adj_re) rowvld_rd_q <= row_vld_q[adj_raddr];
    end
  end

endmodule

// File: src/gdbo_checker.sv
// Port-level checker for the traversal core, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gdbo_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_opcode_i,
  input logic [gdbo_pkg::VtxW-1:0] in_vertex_a_i,
  input logic [gdbo_pkg::VtxW-1:0] in_vertex_b_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [gdbo_pkg::VtxW-1:0] out_vertex_i,
  input logic                      out_last_i
);
  import gdbo_pkg::*;

  logic in_fire;
  logic a_ok, b_ok;

  assign in_fire = in_valid_i && in_ready_i;
  assign a_ok    = (in_vertex_a_i != '0) && (in_vertex_a_i <= VtxW'(MaxVertices));
  assign b_ok    = (in_vertex_b_i != '0) && (in_vertex_b_i <= VtxW'(MaxVertices));

  // a stalled visit word keeps its payload
  `GDBO_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_vertex_i) && $stable(out_last_i))

  // every visit word names a vertex in range
  `GDBO_ASSERT_IMP(a_out_range, clk_i, rst_ni, out_valid_i, out_vertex_i != '0 && out_vertex_i <= VtxW'(MaxVertices))

  // a valid edge keeps the core busy for its row updates
  `GDBO_ASSERT_NXT(a_edge_busy, clk_i, rst_ni, in_fire && in_opcode_i == OpEdge && a_ok && b_ok, !in_ready_i)

  // a valid run takes the core out of idle, so ready drops
  `GDBO_ASSERT_NXT(a_run_busy, clk_i, rst_ni, in_fire && in_opcode_i == OpRun && a_ok, !in_ready_i)

endmodule

bind graph_dfs_bfs_order_core gdbo_checker u_gdbo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_opcode_i   (in_i.opcode),
  .in_vertex_a_i (in_i.vertex_a),
  .in_vertex_b_i (in_i.vertex_b),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_vertex_i  (out_o.visited_vertex),
  .out_last_i    (out_o.last_of_run)
);

// File: tb/testbench.sv
// Testbench for the graph traversal core: edge/run words against a traversal predictor
`timescale 1ns / 1ps

module testbench;
  import gdbo_pkg::*;

  // one expected visit word
  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic            last;
  } visit_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [VtxW-1:0] cfg_wdata_i;

  gdbo_in_if  cmd ();
  gdbo_out_if vis ();

  graph_dfs_bfs_order_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (cmd),
    .out_o       (vis),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state: graph, visited set, vertex count register
  logic [MaxVertices-1:0] adj_rows [MaxVertices];
  logic [MaxVertices-1:0] seen;
  logic [VtxW-1:0]        vcount_reg;

  visit_t expected_visits [$];
  int     fail_count;
  int     send_idle_pct;
  int     recv_stall_pct;

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // vertex count in effect, saturated
  function automatic int scan_limit();
    return (int'(vcount_reg) > MaxVertices) ? MaxVertices : int'(vcount_reg);
  endfunction

  // lowest unvisited neighbour of u at index >= from, 0 if none
  function automatic int first_unseen(int u, int from, int lim);
    for (int i = from; i <= lim; i++) begin
      if (adj_rows[u-1][i-1] && !seen[i-1]) return i;
    end
    return 0;
  endfunction

  // update the graph or queue up the visit order of one command word
  function automatic void predict_word(logic op, int a, int b, logic bf);
    int lim;
    int sp;
    int head;
    int tail;
    int nxt;
    int u;
    int pos;
    int stack_v [MaxVertices];
    int stack_pos [MaxVertices];
    int fifo [MaxVertices];
    int order [$];
    visit_t w;
    lim = scan_limit();
    if (op == OpEdge) begin
      if (a >= 1 && a <= MaxVertices && b >= 1 && b <= MaxVertices) begin
        adj_rows[a-1][b-1] = 1'b1;
        adj_rows[b-1][a-1] = 1'b1;
      end
      return;
    end
    if (a < 1 || a > MaxVertices) return;
    seen = '0;
    seen[a-1] = 1'b1;
    if (!bf) begin
      // depth first with explicit stack of (vertex, resume index)
      order.push_back(a);
      stack_v[0] = a;
      stack_pos[0] = 1;
      sp = 1;
      while (sp > 0) begin
        nxt = first_unseen(stack_v[sp-1], stack_pos[sp-1], lim);
        if (nxt == 0) begin
          sp--;
        end else begin
          stack_pos[sp-1] = nxt + 1;
          seen[nxt-1] = 1'b1;
          order.push_back(nxt);
          if (sp < MaxVertices) begin
            stack_v[sp] = nxt;
            stack_pos[sp] = 1;
            sp++;
          end
        end
      end
    end else begin
      // breadth first, vertices marked when queued
      fifo[0] = a;
      head = 0;
      tail = 1;
      while (head < tail) begin
        u = fifo[head];
        head++;
        order.push_back(u);
        pos = 1;
        nxt = first_unseen(u, pos, lim);
        while (nxt != 0) begin
          seen[nxt-1] = 1'b1;
          if (tail < MaxVertices) begin
            fifo[tail] = nxt;
            tail++;
          end
          pos = nxt + 1;
          nxt = first_unseen(u, pos, lim);
        end
      end
    end
    foreach (order[i]) begin
      w.vertex = VtxW'(order[i]);
      w.last   = (i == order.size() - 1);
      expected_visits.push_back(w);
    end
  endfunction

  // drive one command word and hold it until accepted
  task automatic send_word(logic op, int a, int b, logic bf);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk_i);
    end
    predict_word(op, a, b, bf);
    cmd.valid         <= 1'b1;
    cmd.opcode        <= op;
    cmd.vertex_a      <= VtxW'(a);
    cmd.vertex_b      <= VtxW'(b);
    cmd.breadth_first <= bf;
    do @(posedge clk_i); while (cmd.ready !== 1'b1);
  endtask

  // stop sending, wait for all visits, then let an edge update settle
  task automatic wait_idle();
    @(negedge clk_i);
    cmd.valid <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(int v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= VtxW'(v);
    vcount_reg   = VtxW'(v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    vis.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each visit word with the oldest expectation
  always @(posedge clk_i) begin
    visit_t exp_w;
    if (rst_ni && vis.valid === 1'b1 && vis.ready === 1'b1) begin
      if (expected_visits.size() == 0) begin
        $error("unexpected visit word: visited_vertex %0d last_of_run %0d",
               vis.visited_vertex, vis.last_of_run);
        fail_count++;
      end else begin
        exp_w = expected_visits.pop_front();
        if (vis.visited_vertex !== exp_w.vertex) begin
          $error("visited_vertex: expected %0d, got %0d", exp_w.vertex, vis.visited_vertex);
          fail_count++;
        end
        if (vis.last_of_run !== exp_w.last) begin
          $error("last_of_run: expected %0d, got %0d", exp_w.last, vis.last_of_run);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_graph();
    send_word(OpRun, 1, 0, 1'b0);
    send_word(OpRun, 64, 127, 1'b1);
  endtask

  // valid edges, a self loop, out-of-range endpoints, then both orders
  task automatic test_edge_rules();
    send_word(OpEdge, 1, 2, 1'b0);
    send_word(OpEdge, 1, 3, 1'b1);
    send_word(OpEdge, 2, 4, 1'b0);
    send_word(OpEdge, 3, 4, 1'b0);
    send_word(OpEdge, 64, 1, 1'b0);
    send_word(OpEdge, 5, 5, 1'b0);
    send_word(OpEdge, 0, 3, 1'b0);
    send_word(OpEdge, 3, 65, 1'b0);
    send_word(OpEdge, 127, 127, 1'b1);
    send_word(OpRun, 1, 0, 1'b0);
    send_word(OpRun, 1, 64, 1'b1);
    send_word(OpRun, 64, 1, 1'b0);
  endtask

  // start vertex zero or above the matrix gives nothing; a valid start then runs breadth first
  task automatic test_run_start_range();
    send_word(OpRun, 0, 1, 1'b0);
    send_word(OpRun, 127, 127, 1'b1);
    send_word(OpRun, 65, 2, 1'b0);
    send_word(OpRun, 4, 0, 1'b1);
  endtask

  // start above count, zero count, saturated count, count of one
  task automatic test_count_limits();
    write_vertex_count(3);
    send_word(OpRun, 4, 0, 1'b0);
    send_word(OpRun, 64, 0, 1'b1);
    write_vertex_count(0);
    send_word(OpRun, 1, 0, 1'b0);
    write_vertex_count(127);
    send_word(OpRun, 2, 0, 1'b1);
    write_vertex_count(1);
    send_word(OpRun, 1, 0, 1'b0);
    send_word(OpRun, 64, 0, 1'b1);
  endtask

  // rounds of random count setting followed by mixed edge and run words
  task automatic test_random_traffic(int target);
    int done_items;
    int pick;
    int v;
    int n_eff;
    int a;
    int b;
    int off;
    done_items = 0;
    while (done_items < target) begin
      pick = $urandom_range(99);
      if (pick < 40)      v = $urandom_range(2, 12);
      else if (pick < 60) v = $urandom_range(13, 40);
      else if (pick < 80) v = 64;
      else if (pick < 90) v = $urandom_range(0, 1);
      else                v = $urandom_range(65, 127);
      write_vertex_count(v);
      n_eff = (v > MaxVertices) ? MaxVertices : ((v < 1) ? 1 : v);
      repeat ($urandom_range(4, 12)) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          if ($urandom_range(19) == 0) begin
            // endpoint outside the matrix
            a = $urandom_range(1) ? 0 : $urandom_range(65, 127);
            b = $urandom_range(127);
            if ($urandom_range(1)) send_word(OpEdge, b, a, 1'($urandom_range(1)));
            else send_word(OpEdge, a, b, 1'($urandom_range(1)));
          end else begin
            if ($urandom_range(3) == 0) begin
              a = $urandom_range(1, 64);
              b = $urandom_range(1, 64);
            end else begin
              // short-range edge keeps long connected paths around
              a = $urandom_range(1) ? $urandom_range(1, (n_eff + 2 > 64) ? 64 : n_eff + 2)
                                    : $urandom_range(1, 64);
              off = $urandom_range(1, 3);
              b = $urandom_range(1) ? a + off : a - off;
              if (b > 64) b = 64;
              if (b < 1) b = 1;
            end
            send_word(OpEdge, a, b, 1'($urandom_range(1)));
            done_items++;
          end
        end else begin
          pick = $urandom_range(99);
          if (pick < 70)      a = $urandom_range(1, n_eff);
          else if (pick < 90) a = $urandom_range(1, 64);
          else                a = $urandom_range(1) ? 0 : $urandom_range(65, 127);
          send_word(OpRun, a, $urandom_range(127), 1'($urandom_range(1)));
          if (a >= 1 && a <= 64) done_items++;
        end
      end
    end
  endtask

  // run limit
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    foreach (adj_rows[i]) adj_rows[i] = '0;
    seen              = '0;
    vcount_reg        = VtxW'(64);
    fail_count        = 0;
    send_idle_pct     = 24;
    recv_stall_pct    = 53;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    cmd.valid         = 1'b0;
    cmd.opcode        = OpEdge;
    cmd.vertex_a      = '0;
    cmd.vertex_b      = '0;
    cmd.breadth_first = 1'b0;
    vis.ready         = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_graph();
    test_edge_rules();
    test_run_start_range();
    test_count_limits();
    test_random_traffic(125);

    send_idle_pct  = 53;
    recv_stall_pct = 24;
    test_random_traffic(125);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(125);

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
